/* hdl/sft_pkg.sv */
package sft_pkg;

  localparam int AVG_TAPS_DEF = 3;
  localparam int Q_DEPTH_DEF  = 4;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_RESET  = 2'd1;
  localparam logic [1:0] KIND_FORCE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WATER_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WATER_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EC_LOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EC_HIGH    = 2'd3;

  localparam logic [6:0]  WATER_LOW_RST  = 7'd10;
  localparam logic [6:0]  WATER_HIGH_RST = 7'd60;
  localparam logic [12:0] EC_LOW_RST     = 13'd700;
  localparam logic [12:0] EC_HIGH_RST    = 13'd2000;

  typedef enum logic [2:0] {
    EVT_STATUS    = 3'd0,
    EVT_WATER_LOW = 3'd1,
    EVT_EC_LOW    = 3'd2,
    EVT_WATER_OK  = 3'd3,
    EVT_EC_OK     = 3'd4
  } evt_t;

  typedef enum logic {
    ALM_NORMAL = 1'b0,
    ALM_LOW    = 1'b1
  } alarm_t;

  typedef struct packed {
    logic clear;
    logic forced;
    logic normal;
  } alm_cmd_t;

  typedef struct packed {
    evt_t        ev0;
    evt_t        ev1;
    logic [1:0]  nev;
    logic [15:0] temp;
    logic [15:0] humid;
    logic [12:0] ec_ppm;
    logic [6:0]  wpct;
    logic [15:0] level;
    logic [19:0] ema;
    logic [1:0]  mask;
    logic        bus;
  } rec_t;

endpackage

/* hdl/sensor_filter_threshold_alarm_top.sv */
// Sensor sample filter with low/recover alarms. Every input transaction
// runs through a five-stage front pipeline (held codes, scaling, moving
// average and EMA state, average divide, alarm FSMs); a sample then
// leaves a record in a small queue, and the result sequencer emits one
// result per cycle from it while out_ready is high: the alarm events
// first, then the status result with out_last set, so a sample yields one
// to three results. Input ready drops only when a sample sits in the alarm
// stage and the queue is full, so reset and force transactions are taken
// one per cycle while in_ready is high; new samples are taken while the
// queue has room, and their sustained rate is set by the number of results
// the output side has to deliver.
module sensor_filter_threshold_alarm_top #(
  parameter int AVG_TAPS    = sft_pkg::AVG_TAPS_DEF,
  parameter int QUEUE_DEPTH = sft_pkg::Q_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic signed [15:0]             in_water_raw,
  input  logic signed [15:0]             in_ec_raw,
  input  logic                           in_read_ok,
  input  logic [15:0]                    in_temperature_x10,
  input  logic [15:0]                    in_humidity_x10,
  input  logic                           in_recovery_active,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     out_event_res,
  output logic [15:0]                    out_temp_out,
  output logic [15:0]                    out_humid_out,
  output logic [12:0]                    out_ec_ppm,
  output logic [6:0]                     out_water_percent,
  output logic signed [15:0]             out_water_level_q8,
  output logic signed [19:0]             out_ec_filtered_q7,
  output logic [1:0]                     out_alarm_mask,
  output logic                           out_bus_reset,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sft_pkg::CFG_DATA_W-1:0] cfg_data
);

  logic          q_push;
  logic          q_full;
  logic          q_pop;
  logic          q_empty;
  sft_pkg::rec_t q_wdata;
  sft_pkg::rec_t q_head;

  sft_front #(
    .AVG_TAPS (AVG_TAPS)
  ) u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_water_raw       (in_water_raw),
    .in_ec_raw          (in_ec_raw),
    .in_read_ok         (in_read_ok),
    .in_temperature_x10 (in_temperature_x10),
    .in_humidity_x10    (in_humidity_x10),
    .in_recovery_active (in_recovery_active),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .q_push             (q_push),
    .q_data             (q_wdata),
    .q_full             (q_full)
  );

  sft_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  sft_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_event_res      (out_event_res),
    .out_temp_out       (out_temp_out),
    .out_humid_out      (out_humid_out),
    .out_ec_ppm         (out_ec_ppm),
    .out_water_percent  (out_water_percent),
    .out_water_level_q8 (out_water_level_q8),
    .out_ec_filtered_q7 (out_ec_filtered_q7),
    .out_alarm_mask     (out_alarm_mask),
    .out_bus_reset      (out_bus_reset),
    .out_last           (out_last)
  );

endmodule

/* hdl/sft_alarm.sv */
module sft_alarm (
  input  logic              clk,
  input  logic              rst_n,
  input  sft_pkg::alm_cmd_t cmd,
  input  logic              below,
  input  logic              in_band,
  output logic              alarm_on,
  output logic              raise,
  output logic              recover
);

  sft_pkg::alarm_t state_r;
  sft_pkg::alarm_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sft_pkg::ALM_NORMAL: begin
        if (cmd.clear) begin
          state_nxt = sft_pkg::ALM_NORMAL;
        end else if ((cmd.forced || cmd.normal) && below) begin
          state_nxt = sft_pkg::ALM_LOW;
        end
      end
      sft_pkg::ALM_LOW: begin
        if (cmd.clear) begin
          state_nxt = sft_pkg::ALM_NORMAL;
        end else if (cmd.normal && in_band) begin
          state_nxt = sft_pkg::ALM_NORMAL;
        end
      end
      default: state_nxt = sft_pkg::ALM_NORMAL;
    endcase
  end

  always_comb begin
    raise    = 1'b0;
    recover  = 1'b0;
    alarm_on = (state_nxt == sft_pkg::ALM_LOW);
    unique case (state_r)
      sft_pkg::ALM_NORMAL: begin
        raise = (cmd.forced || cmd.normal) && below;
      end
      sft_pkg::ALM_LOW: begin
        raise   = cmd.forced && below;
        recover = cmd.normal && in_band;
      end
      default: begin
        raise   = 1'b0;
        recover = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sft_pkg::ALM_NORMAL;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hdl/sft_front.sv */
module sft_front #(
  parameter int AVG_TAPS = sft_pkg::AVG_TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_kind,
  input  logic signed [15:0]               in_water_raw,
  input  logic signed [15:0]               in_ec_raw,
  input  logic                             in_read_ok,
  input  logic [15:0]                      in_temperature_x10,
  input  logic [15:0]                      in_humidity_x10,
  input  logic                             in_recovery_active,
  input  logic                             cfg_we,
  input  logic [sft_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sft_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             q_push,
  output sft_pkg::rec_t                    q_data,
  input  logic                             q_full
);

  localparam int IDX_W  = $clog2(AVG_TAPS);
  localparam int SUM_W  = 16 + IDX_W;
  localparam int AVG_N  = SUM_W - 1;
  localparam int AVG_S  = AVG_N + IDX_W;
  localparam int AVG_MW = AVG_N + 1;
  localparam int AVG_PW = AVG_N + AVG_MW;
  localparam logic [AVG_MW-1:0] AVG_M =
    AVG_MW'(((64'd1 << AVG_S) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

  localparam int          SC_DIV = 33;
  localparam int          SC_S   = 26;
  localparam logic [20:0] SC_M   = 21'(((64'd1 << SC_S) + 64'(SC_DIV) - 64'd1) / 64'(SC_DIV));

  localparam int          EMA_DIV = 5;
  localparam int          EMA_S   = 25;
  localparam logic [22:0] EMA_M   =
    23'(((64'd1 << EMA_S) + 64'(EMA_DIV) - 64'd1) / 64'(EMA_DIV));

  localparam logic [1:0] FAIL_LAST = 2'd2;

  logic adv;
  logic acc;
  logic kind_ok;

  logic [6:0]  wlow_r;
  logic [6:0]  whigh_r;
  logic [12:0] elow_r;
  logic [12:0] ehigh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlow_r  <= sft_pkg::WATER_LOW_RST;
      whigh_r <= sft_pkg::WATER_HIGH_RST;
      elow_r  <= sft_pkg::EC_LOW_RST;
      ehigh_r <= sft_pkg::EC_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sft_pkg::CFG_WATER_LOW:  wlow_r  <= cfg_data[6:0];
        sft_pkg::CFG_WATER_HIGH: whigh_r <= cfg_data[6:0];
        sft_pkg::CFG_EC_LOW:     elow_r  <= cfg_data;
        sft_pkg::CFG_EC_HIGH:    ehigh_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input stage: hold last good codes and count failed reads.
  logic [15:0] held_w_r, held_w_nxt;
  logic [15:0] held_e_r, held_e_nxt;
  logic [1:0]  fail_r, fail_nxt;
  logic        bus_nxt;

  assign in_ready = adv;
  assign acc      = in_valid && adv;
  assign kind_ok  = (in_kind == sft_pkg::KIND_SAMPLE) || (in_kind == sft_pkg::KIND_RESET) ||
                    (in_kind == sft_pkg::KIND_FORCE);

  always_comb begin
    held_w_nxt = held_w_r;
    held_e_nxt = held_e_r;
    fail_nxt   = fail_r;
    bus_nxt    = 1'b0;
    if (in_read_ok) begin
      held_w_nxt = in_water_raw;
      held_e_nxt = in_ec_raw;
      fail_nxt   = 2'd0;
    end else if (fail_r == FAIL_LAST) begin
      bus_nxt  = 1'b1;
      fail_nxt = 2'd0;
    end else begin
      fail_nxt = fail_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_w_r <= '0;
      held_e_r <= '0;
      fail_r   <= '0;
    end else if (acc && in_kind == sft_pkg::KIND_SAMPLE) begin
      held_w_r <= held_w_nxt;
      held_e_r <= held_e_nxt;
      fail_r   <= fail_nxt;
    end
  end

  logic        p1_valid_r;
  logic [1:0]  p1_kind_r;
  logic [15:0] p1_hw_r;
  logic [15:0] p1_he_r;
  logic        p1_bus_r;
  logic [15:0] p1_temp_r;
  logic [15:0] p1_hum_r;
  logic        p1_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= in_valid && kind_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_kind_r <= in_kind;
      p1_hw_r   <= held_w_nxt;
      p1_he_r   <= held_e_nxt;
      p1_bus_r  <= bus_nxt;
      p1_temp_r <= in_temperature_x10;
      p1_hum_r  <= in_humidity_x10;
      p1_rec_r  <= in_recovery_active;
    end
  end

  // Scale stage: level = floor(raw * 32 / 33), EC in 1/128 ppm.
  logic [20:0] sc_x;
  logic        sc_neg;
  logic [19:0] sc_u;
  logic [40:0] sc_prod;
  logic [14:0] sc_q;
  logic [15:0] level_now;
  logic [19:0] ec_now;

  assign sc_x      = {p1_hw_r, 5'b00000};
  assign sc_neg    = sc_x[20];
  assign sc_u      = sc_neg ? ~sc_x[19:0] : sc_x[19:0];
  assign sc_prod   = sc_u * SC_M;
  assign sc_q      = sc_prod[SC_S +: 15];
  assign level_now = sc_neg ? ~{1'b0, sc_q} : {1'b0, sc_q};
  assign ec_now    = {p1_he_r, 4'b0000};

  logic        p2_valid_r;
  logic [1:0]  p2_kind_r;
  logic [15:0] p2_lvl_r;
  logic [19:0] p2_ec_r;
  logic        p2_bus_r;
  logic [15:0] p2_temp_r;
  logic [15:0] p2_hum_r;
  logic        p2_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (adv) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2_kind_r <= p1_kind_r;
      p2_lvl_r  <= level_now;
      p2_ec_r   <= ec_now;
      p2_bus_r  <= p1_bus_r;
      p2_temp_r <= p1_temp_r;
      p2_hum_r  <= p1_hum_r;
      p2_rec_r  <= p1_rec_r;
    end
  end

  // Filter stage: running sum over the average buffer and the EMA step.
  logic [15:0]      avg_buf_r [AVG_TAPS];
  logic [IDX_W-1:0] avg_idx_r, avg_idx_nxt;
  logic             avg_full_r, avg_full_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [19:0]      ema_r, ema_nxt;
  logic             ema_valid_r;
  logic             idx_last;
  logic [15:0]      old_lvl;
  logic             upd2;

  logic [22:0] em_s;
  logic        em_neg;
  logic [21:0] em_u;
  logic [44:0] em_prod;
  logic [18:0] em_q;
  logic [19:0] em_div;

  assign upd2         = adv && p2_valid_r;
  assign old_lvl      = avg_buf_r[avg_idx_r];
  assign sum_nxt      = sum_r - {{IDX_W{old_lvl[15]}}, old_lvl} +
                        {{IDX_W{p2_lvl_r[15]}}, p2_lvl_r};
  assign idx_last     = (avg_idx_r == IDX_W'(AVG_TAPS - 1));
  assign avg_idx_nxt  = idx_last ? '0 : avg_idx_r + 1'b1;
  assign avg_full_nxt = avg_full_r | idx_last;

  assign em_s    = {{3{p2_ec_r[19]}}, p2_ec_r} + {ema_r[19], ema_r, 2'b00};
  assign em_neg  = em_s[22];
  assign em_u    = em_neg ? ~em_s[21:0] : em_s[21:0];
  assign em_prod = em_u * EMA_M;
  assign em_q    = em_prod[EMA_S +: 19];
  assign em_div  = em_neg ? ~{1'b0, em_q} : {1'b0, em_q};
  assign ema_nxt = ema_valid_r ? em_div : p2_ec_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (upd2 && p2_kind_r == sft_pkg::KIND_RESET)) begin
      for (int i = 0; i < AVG_TAPS; i++) begin
        avg_buf_r[i] <= '0;
      end
      avg_idx_r   <= '0;
      avg_full_r  <= 1'b0;
      sum_r       <= '0;
      ema_r       <= '0;
      ema_valid_r <= 1'b0;
    end else if (upd2 && p2_kind_r == sft_pkg::KIND_SAMPLE) begin
      avg_buf_r[avg_idx_r] <= p2_lvl_r;
      avg_idx_r            <= avg_idx_nxt;
      avg_full_r           <= avg_full_nxt;
      sum_r                <= sum_nxt;
      ema_r                <= ema_nxt;
      ema_valid_r          <= 1'b1;
    end
  end

  logic             p3_valid_r;
  logic [1:0]       p3_kind_r;
  logic [15:0]      p3_lvl_r;
  logic [SUM_W-1:0] p3_sum_r;
  logic             p3_full_r;
  logic [19:0]      p3_ema_r;
  logic             p3_bus_r;
  logic [15:0]      p3_temp_r;
  logic [15:0]      p3_hum_r;
  logic             p3_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_valid_r <= 1'b0;
    end else if (adv) begin
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p3_kind_r <= p2_kind_r;
      p3_lvl_r  <= p2_lvl_r;
      p3_sum_r  <= sum_nxt;
      p3_full_r <= avg_full_nxt;
      p3_ema_r  <= ema_nxt;
      p3_bus_r  <= p2_bus_r;
      p3_temp_r <= p2_temp_r;
      p3_hum_r  <= p2_hum_r;
      p3_rec_r  <= p2_rec_r;
    end
  end

  // Average stage: floor(sum / AVG_TAPS) once the buffer has filled.
  logic              av_neg;
  logic [AVG_N-1:0]  av_u;
  logic [AVG_PW-1:0] av_prod;
  logic [14:0]       av_q;
  logic [15:0]       av_lvl;
  logic [15:0]       level;

  assign av_neg  = p3_sum_r[SUM_W-1];
  assign av_u    = av_neg ? ~p3_sum_r[AVG_N-1:0] : p3_sum_r[AVG_N-1:0];
  assign av_prod = av_u * AVG_M;
  assign av_q    = av_prod[AVG_S +: 15];
  assign av_lvl  = av_neg ? ~{1'b0, av_q} : {1'b0, av_q};
  assign level   = p3_full_r ? av_lvl : p3_lvl_r;

  logic        p4_valid_r;
  logic [1:0]  p4_kind_r;
  logic [15:0] p4_lvl_r;
  logic [19:0] p4_ema_r;
  logic        p4_bus_r;
  logic [15:0] p4_temp_r;
  logic [15:0] p4_hum_r;
  logic        p4_rec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_valid_r <= 1'b0;
    end else if (adv) begin
      p4_valid_r <= p3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p4_kind_r <= p3_kind_r;
      p4_lvl_r  <= level;
      p4_ema_r  <= p3_ema_r;
      p4_bus_r  <= p3_bus_r;
      p4_temp_r <= p3_temp_r;
      p4_hum_r  <= p3_hum_r;
      p4_rec_r  <= p3_rec_r;
    end
  end

  // Alarm stage: threshold compares, alarm FSMs and record build.
  logic              upd4;
  logic              is_s4;
  logic              force_r;
  sft_pkg::alm_cmd_t cmd;
  logic              w_below, w_band, e_below, e_band;
  logic              w_on, w_raise, w_recover;
  logic              e_on, e_raise, e_recover;
  logic              w_has, e_has;
  sft_pkg::evt_t     w_code, e_code;

  assign adv   = !(p4_valid_r && p4_kind_r == sft_pkg::KIND_SAMPLE && q_full);
  assign upd4  = adv && p4_valid_r;
  assign is_s4 = (p4_kind_r == sft_pkg::KIND_SAMPLE);

  assign cmd.clear  = upd4 && (p4_kind_r == sft_pkg::KIND_RESET);
  assign cmd.forced = upd4 && is_s4 && force_r;
  assign cmd.normal = upd4 && is_s4 && !force_r && !p4_rec_r;

  assign w_below = $signed({p4_lvl_r[15], p4_lvl_r}) < $signed({2'b00, wlow_r, 8'h00});
  assign w_band  = !w_below &&
                   ($signed({p4_lvl_r[15], p4_lvl_r}) <= $signed({2'b00, whigh_r, 8'h00}));
  assign e_below = $signed({p4_ema_r[19], p4_ema_r}) < $signed({1'b0, elow_r, 7'h00});
  assign e_band  = !e_below &&
                   ($signed({p4_ema_r[19], p4_ema_r}) <= $signed({1'b0, ehigh_r, 7'h00}));

  sft_alarm u_water_alarm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .below    (w_below),
    .in_band  (w_band),
    .alarm_on (w_on),
    .raise    (w_raise),
    .recover  (w_recover)
  );

  sft_alarm u_ec_alarm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .below    (e_below),
    .in_band  (e_band),
    .alarm_on (e_on),
    .raise    (e_raise),
    .recover  (e_recover)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_r <= 1'b0;
    end else if (upd4) begin
      case (p4_kind_r) inside
        sft_pkg::KIND_SAMPLE:                    force_r <= 1'b0;
        sft_pkg::KIND_RESET, sft_pkg::KIND_FORCE: force_r <= 1'b1;
        default: ;
      endcase
    end
  end

  assign w_has  = w_raise || w_recover;
  assign e_has  = e_raise || e_recover;
  assign w_code = w_raise ? sft_pkg::EVT_WATER_LOW : sft_pkg::EVT_WATER_OK;
  assign e_code = e_raise ? sft_pkg::EVT_EC_LOW : sft_pkg::EVT_EC_OK;

  assign q_push       = upd4 && is_s4;
  assign q_data.ev0   = w_has ? w_code : e_code;
  assign q_data.ev1   = e_code;
  assign q_data.nev   = {1'b0, w_has} + {1'b0, e_has};
  assign q_data.temp  = p4_temp_r;
  assign q_data.humid = p4_hum_r;
  assign q_data.ec_ppm = p4_ema_r[19] ? 13'd0 : {1'b0, p4_ema_r[18:7]};
  assign q_data.wpct  = p4_lvl_r[15] ? 7'd0 : p4_lvl_r[14:8];
  assign q_data.level = p4_lvl_r;
  assign q_data.ema   = p4_ema_r;
  assign q_data.mask  = {e_on, w_on};
  assign q_data.bus   = p4_bus_r;

endmodule

/* hdl/sft_fifo.sv */
module sft_fifo #(
  parameter int DEPTH = sft_pkg::Q_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sft_pkg::rec_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output sft_pkg::rec_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  sft_pkg::rec_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
  assign cnt_nxt    = cnt_r + CNT_W'(push) - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

/* hdl/sft_back.sv */
module sft_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  sft_pkg::rec_t        q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_event_res,
  output logic [15:0]          out_temp_out,
  output logic [15:0]          out_humid_out,
  output logic [12:0]          out_ec_ppm,
  output logic [6:0]           out_water_percent,
  output logic signed [15:0]   out_water_level_q8,
  output logic signed [19:0]   out_ec_filtered_q7,
  output logic [1:0]           out_alarm_mask,
  output logic                 out_bus_reset,
  output logic                 out_last
);

  sft_pkg::rec_t rec_r;
  logic          vld_r, vld_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          fire;
  logic          take;

  assign out_last = (k_r == rec_r.nev);
  assign fire     = vld_r && out_ready;
  assign take     = !vld_r || (fire && out_last);
  assign q_pop    = take && !q_empty;

  always_comb begin
    vld_nxt = vld_r;
    k_nxt   = k_r;
    if (take) begin
      vld_nxt = !q_empty;
      k_nxt   = 2'd0;
    end else if (fire) begin
      k_nxt = k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      k_r   <= 2'd0;
    end else begin
      vld_r <= vld_nxt;
      k_r   <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec_r <= q_head;
    end
  end

  assign out_valid          = vld_r;
  assign out_event_res      = out_last ? sft_pkg::EVT_STATUS :
                              ((k_r == 2'd0) ? rec_r.ev0 : rec_r.ev1);
  assign out_temp_out       = rec_r.temp;
  assign out_humid_out      = rec_r.humid;
  assign out_ec_ppm         = rec_r.ec_ppm;
  assign out_water_percent  = rec_r.wpct;
  assign out_water_level_q8 = rec_r.level;
  assign out_ec_filtered_q7 = rec_r.ema;
  assign out_alarm_mask     = rec_r.mask;
  assign out_bus_reset      = rec_r.bus;

  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> (k_r <= rec_r.nev))
    else $error("result index past the last event");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r && out_ready && !out_last) |=> (vld_r && (k_r == $past(k_r) + 2'd1)))
    else $error("result index did not advance after a transaction");

endmodule
